FILE: design/exsort_pkg.sv
// Shared constants, payload types and sequencer states for the exchange sorter.
`timescale 1ns / 1ps

package exsort_pkg;

  // Store size, the index and count widths that follow from it, and the data width.
  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 32;

  // One input transfer.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflowed;
  } out_t;

  // Request from the sequencer to the element store.
  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_I,
    ST_GET_I,
    ST_CMP,
    ST_WR_I,
    ST_RD_K,
    ST_LD_K,
    ST_SEND
  } state_t;

endpackage

FILE: design/exsort_store.sv
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps

module exsort_store (
  input  logic                                  clk,
  input  exsort_pkg::mem_req_t                  req,
  output logic signed [exsort_pkg::DATA_W-1:0]  rdata
);

  logic signed [exsort_pkg::DATA_W-1:0] mem [exsort_pkg::MAX_ITEMS];

  // Write first-come, read data registered.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

FILE: design/exsort_cmp.sv
// Shared signed comparator that decides whether two entries are out of order.
`timescale 1ns / 1ps

module exsort_cmp (
  input  logic signed [exsort_pkg::DATA_W-1:0] a,
  input  logic signed [exsort_pkg::DATA_W-1:0] b,
  input  logic                                 desc,
  output logic                                 swap
);

  // Equal values never swap.
  always_comb begin
    if (desc) begin
      swap = (a < b);
    end else begin
      swap = (a > b);
    end
  end

endmodule

FILE: design/exsort_seq.sv
// Sequencer: collects the set, runs the exchange sort and streams the results.
`timescale 1ns / 1ps

module exsort_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  descending,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  exsort_pkg::in_t                       in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output exsort_pkg::out_t                      out_data,
  output exsort_pkg::mem_req_t                  mem_req,
  input  logic signed [exsort_pkg::DATA_W-1:0]  rdata
);

  exsort_pkg::state_t                    state, state_next;
  logic [exsort_pkg::CNT_W-1:0]          count, count_next;
  logic                                  ovf, ovf_next;
  logic                                  desc_q, desc_next;
  logic [exsort_pkg::IDX_W-1:0]          i, i_next;
  logic [exsort_pkg::IDX_W-1:0]          j, j_next;
  logic [exsort_pkg::IDX_W-1:0]          k, k_next;
  logic signed [exsort_pkg::DATA_W-1:0]  held, held_next;
  logic                                  out_valid_next;
  exsort_pkg::out_t                      out_data_next;
  logic                                  swap;

  // The one comparator, shared by every compare of the sort.
  exsort_cmp u_cmp (
    .a    (held),
    .b    (rdata),
    .desc (desc_q),
    .swap (swap)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= exsort_pkg::ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ovf       <= ovf_next;
      out_valid <= out_valid_next;
    end
  end

  // Indexes, the held entry and the result payload.
  always_ff @(posedge clk) begin
    desc_q   <= desc_next;
    i        <= i_next;
    j        <= j_next;
    k        <= k_next;
    held     <= held_next;
    out_data <= out_data_next;
  end

  // Next state, store requests and result loading.
  always_comb begin
    logic [exsort_pkg::CNT_W-1:0] count_after;

    state_next     = state;
    count_next     = count;
    ovf_next       = ovf;
    desc_next      = desc_q;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    held_next      = held;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    in_ready       = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.waddr  = i;
    mem_req.wdata  = held;
    mem_req.raddr  = i;
    count_after    = count;

    case (state)
      // Collect values; a value that finds the store full is dropped.
      exsort_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < exsort_pkg::CNT_W'(exsort_pkg::MAX_ITEMS)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count[exsort_pkg::IDX_W-1:0];
            mem_req.wdata = in_data.value;
            count_after   = count + exsort_pkg::CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          count_next = count_after;
          if (in_data.last_item) begin
            desc_next = descending;
            i_next    = '0;
            k_next    = '0;
            if (count_after > exsort_pkg::CNT_W'(1)) begin
              state_next = exsort_pkg::ST_RD_I;
            end else begin
              state_next = exsort_pkg::ST_RD_K;
            end
          end
        end
      end

      // Fetch the entry at position i.
      exsort_pkg::ST_RD_I: begin
        mem_req.raddr = i;
        j_next        = i + exsort_pkg::IDX_W'(1);
        state_next    = exsort_pkg::ST_GET_I;
      end

      // Hold position i and fetch the first later entry.
      exsort_pkg::ST_GET_I: begin
        held_next     = rdata;
        mem_req.raddr = j;
        state_next    = exsort_pkg::ST_CMP;
      end

      // Compare held entry with entry j; a swap writes the held value to j.
      exsort_pkg::ST_CMP: begin
        if (swap) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = j;
          mem_req.wdata = held;
          held_next     = rdata;
        end
        if (exsort_pkg::CNT_W'(j) + exsort_pkg::CNT_W'(1) < count) begin
          j_next        = j + exsort_pkg::IDX_W'(1);
          mem_req.raddr = j + exsort_pkg::IDX_W'(1);
        end else begin
          state_next = exsort_pkg::ST_WR_I;
        end
      end

      // Write back the settled entry of position i.
      exsort_pkg::ST_WR_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i;
        mem_req.wdata = held;
        i_next        = i + exsort_pkg::IDX_W'(1);
        if (exsort_pkg::CNT_W'(i) + exsort_pkg::CNT_W'(2) < count) begin
          state_next = exsort_pkg::ST_RD_I;
        end else begin
          k_next     = '0;
          state_next = exsort_pkg::ST_RD_K;
        end
      end

      // Fetch result k.
      exsort_pkg::ST_RD_K: begin
        mem_req.raddr = k;
        state_next    = exsort_pkg::ST_LD_K;
      end

      // Load result k into the output register.
      exsort_pkg::ST_LD_K: begin
        out_valid_next             = 1'b1;
        out_data_next.sorted_value = rdata;
        out_data_next.last_out     = (exsort_pkg::CNT_W'(k) + exsort_pkg::CNT_W'(1) == count);
        out_data_next.overflowed   = ovf;
        state_next                 = exsort_pkg::ST_SEND;
      end

      // Wait for the result transfer; after the last one, start a new set.
      exsort_pkg::ST_SEND: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (out_data.last_out) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = exsort_pkg::ST_LOAD;
          end else begin
            k_next     = k + exsort_pkg::IDX_W'(1);
            state_next = exsort_pkg::ST_RD_K;
          end
        end
      end

      default: begin
        state_next = exsort_pkg::ST_LOAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Collection and result output never overlap.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input accepted while a result is pending");

  // The fill count never passes the store size.
  assert property (@(posedge clk) disable iff (rst)
    count <= exsort_pkg::CNT_W'(exsort_pkg::MAX_ITEMS))
    else $error("element count beyond store size");

  // A swap only writes a later position than the one being settled.
  assert property (@(posedge clk) disable iff (rst)
    (state == exsort_pkg::ST_CMP && mem_req.we) |-> (j > i))
    else $error("swap write at or before position i");

  // The final result transfer empties the set and reopens the input.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_out) |=> (in_ready && count == '0 && !ovf))
    else $error("set not cleared after final result");
`endif

endmodule

FILE: design/exchange_sort_up_down.sv
// Top level of the exchange sorter: configuration register, sequencer and store.
`timescale 1ns / 1ps

// Collects up to MAX_ITEMS (16) signed 32-bit values, one per input transfer at
// one cycle each, until a transfer with last_item set; values that find the
// store full are dropped and every result of that set carries overflowed. The
// set of n entries is then sorted in place by an exchange sort that uses one
// comparator and one single-port-write, registered-read memory: each position
// i is fetched, held, compared with each later entry in turn and written back.
// Each result is then fetched, loaded and held until taken, and in_ready stays
// low from the last input transfer until the final result (last_out) is taken.
// The descending bit is sampled when the last item of a set is accepted.
module exchange_sort_up_down (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  exsort_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output exsort_pkg::out_t  out_data
);

  logic                                  descending;
  exsort_pkg::mem_req_t                  mem_req;
  logic signed [exsort_pkg::DATA_W-1:0]  rdata;

  // Sort direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_wen) begin
      descending <= cfg_wdata;
    end
  end

  exsort_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .descending (descending),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mem_req    (mem_req),
    .rdata      (rdata)
  );

  exsort_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

FILE: tb/sv/exchange_sort_up_down_test.sv
// Self-checking testbench for the exchange sorter: sets in both orders, duplicates and overflow.
`timescale 1ns / 1ps

module exchange_sort_up_down_test;
  import exsort_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int SETTLE      = 8;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_wen   = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  exchange_sort_up_down dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mirror of the block: collected values, fill count, drop flag and sort order.
  logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
  int unsigned              held_count    = 0;
  logic                     dropped_any   = 1'b0;
  logic                     order_down    = 1'b0;

  in_t  pending_items [$];
  out_t sorted_expect [$];

  logic no_idle        = 1'b0;
  int   send_gap       = 0;
  int   take_stall     = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  out_t want;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Takes one accepted input and, when it closes a set, queues the sorted results.
  task automatic absorb_item(input in_t item);
    logic signed [DATA_W-1:0] held_tmp;
    logic                     swap;
    out_t                     res;
    if (held_count < MAX_ITEMS) begin
      held_values[held_count] = item.value;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (item.last_item) begin
      for (int i = 0; i + 1 < held_count; i++) begin
        for (int j = i + 1; j < held_count; j++) begin
          swap = order_down ? (held_values[i] < held_values[j])
                            : (held_values[i] > held_values[j]);
          if (swap) begin
            held_tmp       = held_values[i];
            held_values[i] = held_values[j];
            held_values[j] = held_tmp;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        res.sorted_value = held_values[k];
        res.last_out     = (k + 1 == held_count);
        res.overflowed   = dropped_any;
        sorted_expect.push_back(res);
      end
      held_count  = 0;
      dropped_any = 1'b0;
    end
  endtask

  // Value styles: 0 full random, 1 narrow range full of duplicates, 2 mostly extremes.
  function automatic logic signed [DATA_W-1:0] pick_value(input int style);
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    if (style == 1) begin
      v = $signed($urandom_range(0, 8)) - 4;
    end else if (style == 2) begin
      case ($urandom_range(0, 5))
        0: v = {1'b1, {(DATA_W-1){1'b0}}};
        1: v = {1'b0, {(DATA_W-1){1'b1}}};
        2: v = '0;
        3: v = '1;
        4: v = 1;
        default: v = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic push_item(input logic signed [DATA_W-1:0] v, input logic last);
    in_t item;
    item.value     = v;
    item.last_item = last;
    pending_items.push_back(item);
  endtask

  task automatic queue_set(input int count, input int style);
    for (int k = 0; k < count; k++) begin
      push_item(pick_value(style), k == count - 1);
    end
  endtask

  // Single element, extremes, and equal values that must keep their places.
  task automatic queue_directed();
    push_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    push_item({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
    push_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(32'h5555_5555, 1'b1);
    push_item(7, 1'b0);
    push_item(-7, 1'b0);
    push_item(7, 1'b0);
    push_item(7, 1'b1);
  endtask

  // Random sets until the item budget is used; some overrun the store.
  task automatic queue_random_sets(input int item_budget);
    int queued;
    int size;
    queued = 0;
    while (queued < item_budget) begin
      if ($urandom_range(0, 6) == 0) begin
        size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      end else if ($urandom_range(0, 5) == 0) begin
        size = $urandom_range(1, 2);
      end else begin
        size = $urandom_range(1, MAX_ITEMS);
      end
      queue_set(size, $urandom_range(0, 2));
      queued += size;
    end
  endtask

  // Waits until every item is sent and every result has come back.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || sorted_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(input logic down);
    @(posedge clk);
    cfg_wen    <= 1'b1;
    cfg_wdata  <= down;
    order_down  = down;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Input driver: holds each transfer until taken, with random gaps between items unless no_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        absorb_item(in_data);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 && !no_idle && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (sorted_expect.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("unexpected result: value %0d last %b overflow %b",
                     out_data.sorted_value, out_data.last_out, out_data.overflowed);
          end
        end else begin
          want = sorted_expect.pop_front();
          if (out_data.sorted_value !== want.sorted_value ||
              out_data.last_out !== want.last_out ||
              out_data.overflowed !== want.overflowed) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                       want.sorted_value, want.last_out, want.overflowed,
                       out_data.sorted_value, out_data.last_out, out_data.overflowed);
            end
          end
        end
      end
      // Random stall bursts on the result side, unless no_idle is set.
      if (take_stall > 0) begin
        take_stall--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        take_stall = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("exchange_sort_up_down_test: errors");
      $finish;
    end
  end

  // Phases: reset order, descending, ascending, then descending with no idling.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    wait_idle();
    write_order(1'b1);
    queue_directed();
    queue_random_sets(135);
    wait_idle();
    write_order(1'b0);
    queue_random_sets(135);
    wait_idle();
    write_order(1'b1);
    no_idle <= 1'b1;
    queue_random_sets(130);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("exchange_sort_up_down_test: clean");
    end else begin
      $display("exchange_sort_up_down_test: errors");
    end
    $finish;
  end

endmodule
